// ===== hw/rtl/csns_pkg.sv =====
// ----------------------------------------------------------------------------
// csns_pkg
// Shared constants, codes and types of the chord slot note sequencer.
// ----------------------------------------------------------------------------
package csns_pkg;

	localparam int SLOTS          = 64;
	localparam int MAX_SOUNDING   = 16;
	localparam int NOTES_PER_SLOT = 8;
	localparam int SLOT_W         = 6;
	localparam int ENTRY_W        = 3;
	localparam int SND_W          = 4;
	localparam int SCNT_W         = 5;
	localparam int NCNT_W         = 4;

	localparam logic [2:0] ACT_TICK  = 3'd0;
	localparam logic [2:0] ACT_START = 3'd1;
	localparam logic [2:0] ACT_STOP  = 3'd2;
	localparam logic [2:0] ACT_LEN   = 3'd3;
	localparam logic [2:0] ACT_NOTE  = 3'd4;
	localparam logic [2:0] ACT_NCNT  = 3'd5;

	localparam logic [1:0] EV_OFF = 2'd0;
	localparam logic [1:0] EV_ON  = 2'd1;
	localparam logic [1:0] EV_ALL = 2'd2;

	localparam logic REG_BEAT_STEP  = 1'b0;
	localparam logic REG_SLOT_COUNT = 1'b1;

	localparam logic [23:0] BEAT_STEP_RST = 24'd699051;

	typedef struct packed {
		logic [1:0]        kind;
		logic [6:0]        note;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} event_t;

endpackage

// ===== hw/rtl/csns_ram.sv =====
// ----------------------------------------------------------------------------
// csns_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module csns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hw/rtl/chord_slot_note_sequencer.sv =====
// ----------------------------------------------------------------------------
// chord_slot_note_sequencer
// Tempo-driven chord loop: ticks advance a position, slot changes emit events.
// ----------------------------------------------------------------------------
// A table write is taken in the idle state; a tick without a move only reads the slot
// length and compares it. A move releases the sounding notes, then compares each slot
// note against the sounding notes and emits it, and closes when it has events.
// Each event waits in a holding register so tlast can mark the last.
// One item at a time; the sequencer sets the rate through its compare loop.
// Reset clears control state and note counts; the slot tables stay unknown.
module chord_slot_note_sequencer (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata: action[2:0], slot_sel[8:3], entry_sel[11:9],
	// length_value[43:12], note_value[50:44], zero fill [55:51]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,
	// m_tdata: event_kind[1:0], note_out[8:2], slot_now[14:9], zero fill [15]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [23:0] cfg_wdata
);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_TICK1  = 4'd1;
	localparam logic [3:0] ST_TICK2  = 4'd2;
	localparam logic [3:0] ST_REL    = 4'd3;
	localparam logic [3:0] ST_NEXT   = 4'd4;
	localparam logic [3:0] ST_SRD    = 4'd5;
	localparam logic [3:0] ST_SWAIT  = 4'd6;
	localparam logic [3:0] ST_SCMP   = 4'd7;
	localparam logic [3:0] ST_SEMIT  = 4'd8;
	localparam logic [3:0] ST_STOPEV = 4'd9;
	localparam logic [3:0] ST_DONE   = 4'd10;
	localparam logic [3:0] ST_SLOTRD = 4'd11;

	logic [3:0]  state_q;
	logic [2:0]  act_q;
	logic        playing_q;
	logic [csns_pkg::SLOT_W-1:0] slot_q;
	logic [31:0] pos_q;
	logic [23:0] beat_step_q;
	logic [6:0]  slot_count_q;
	logic        ncnt_vld_q [csns_pkg::SLOTS];
	logic        ncnt_vld_rd_q;
	logic [6:0]  snd_q [csns_pkg::MAX_SOUNDING];
	logic [csns_pkg::SCNT_W-1:0] scnt_q;
	logic [csns_pkg::SCNT_W-1:0] idx_q;
	logic [csns_pkg::NCNT_W-1:0] k_q;
	logic [6:0]  note_q;
	logic        dup_q;
	logic        pend_q;
	csns_pkg::event_t ev_q;
	csns_pkg::event_t out_q;

	// Input fields.
	logic [2:0]  in_act;
	logic [5:0]  in_slot;
	logic [2:0]  in_entry;
	logic [31:0] in_len;
	logic [6:0]  in_note;
	assign in_act   = s_tdata[2:0];
	assign in_slot  = s_tdata[8:3];
	assign in_entry = s_tdata[11:9];
	assign in_len   = s_tdata[43:12];
	assign in_note  = s_tdata[50:44];

	logic acc;
	assign s_tready = (state_q == ST_IDLE);
	assign acc      = s_tvalid && s_tready;

	// Slot tables.
	logic        len_we, note_we, ncnt_we;
	logic [31:0] len_rd;
	logic [6:0]  note_rd;
	logic [csns_pkg::NCNT_W-1:0] ncnt_rd;
	logic [csns_pkg::NCNT_W-1:0] ncnt_wd;
	logic [csns_pkg::SLOT_W+csns_pkg::ENTRY_W-1:0] note_ra;
	assign len_we  = acc && (in_act == csns_pkg::ACT_LEN) && !playing_q;
	assign note_we = acc && (in_act == csns_pkg::ACT_NOTE) && !playing_q;
	assign ncnt_we = acc && (in_act == csns_pkg::ACT_NCNT) && !playing_q;
	assign note_ra = {slot_q, k_q[csns_pkg::ENTRY_W-1:0]};
	assign ncnt_wd = (in_note > 7'(csns_pkg::NOTES_PER_SLOT)) ?
		csns_pkg::NCNT_W'(csns_pkg::NOTES_PER_SLOT) : in_note[csns_pkg::NCNT_W-1:0];

	csns_ram #(.WIDTH(32), .DEPTH(csns_pkg::SLOTS)) u_len (
		.clk(clk), .we(len_we), .waddr(in_slot), .wdata(in_len),
		.raddr(slot_q), .rdata(len_rd)
	);
	csns_ram #(.WIDTH(7), .DEPTH(csns_pkg::SLOTS * csns_pkg::NOTES_PER_SLOT)) u_notes (
		.clk(clk), .we(note_we), .waddr({in_slot, in_entry}), .wdata(in_note),
		.raddr(note_ra), .rdata(note_rd)
	);
	csns_ram #(.WIDTH(csns_pkg::NCNT_W), .DEPTH(csns_pkg::SLOTS)) u_ncnt (
		.clk(clk), .we(ncnt_we), .waddr(in_slot), .wdata(ncnt_wd),
		.raddr(slot_q), .rdata(ncnt_rd)
	);

	// Note counts read as zero until written; the flag is read with the RAM.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < csns_pkg::SLOTS; i++) ncnt_vld_q[i] <= 1'b0;
			ncnt_vld_rd_q <= 1'b0;
		end else begin
			if (ncnt_we) ncnt_vld_q[in_slot] <= 1'b1;
			ncnt_vld_rd_q <= ncnt_vld_q[slot_q];
		end
	end

	// Shared datapath values.
	logic [32:0] sum;
	logic [31:0] pos_sat;
	logic [6:0]  eff_cnt;
	logic [csns_pkg::NCNT_W-1:0] cur_ncnt;
	assign sum      = {1'b0, pos_q} + {9'd0, beat_step_q};
	assign pos_sat  = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
	assign eff_cnt  = (slot_count_q == 7'd0) ? 7'd1 :
		(slot_count_q > 7'(csns_pkg::SLOTS)) ? 7'(csns_pkg::SLOTS) : slot_count_q;
	assign cur_ncnt = ncnt_vld_rd_q ? ncnt_rd : '0;

	logic ev_busy;
	assign ev_busy = m_tvalid && !m_tready;

	// A new event pushes the held one out; the close of an item marks it last.
	logic new_ev;
	logic out_load;
	assign new_ev   = ((state_q == ST_REL) && (idx_q < scnt_q)) ||
		((state_q == ST_SEMIT) && !dup_q) || (state_q == ST_STOPEV);
	assign out_load = !ev_busy && pend_q && (new_ev || (state_q == ST_DONE));

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
			out_q    <= '0;
		end else if (out_load) begin
			m_tvalid <= 1'b1;
			out_q    <= '{kind: ev_q.kind, note: ev_q.note, slot: ev_q.slot,
				last: (state_q == ST_DONE)};
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			act_q        <= csns_pkg::ACT_TICK;
			playing_q    <= 1'b0;
			slot_q       <= '0;
			pos_q        <= '0;
			beat_step_q  <= csns_pkg::BEAT_STEP_RST;
			slot_count_q <= 7'd1;
			scnt_q       <= '0;
			idx_q        <= '0;
			k_q          <= '0;
			pend_q       <= 1'b0;
			ev_q         <= '0;
			dup_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == csns_pkg::REG_BEAT_STEP) beat_step_q <= cfg_wdata;
				else if (!playing_q) slot_count_q <= cfg_wdata[6:0];
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc) begin
						act_q <= in_act;
						idx_q <= '0;
						unique case (in_act) inside
							csns_pkg::ACT_TICK: if (playing_q) state_q <= ST_TICK1;
							csns_pkg::ACT_START, csns_pkg::ACT_STOP: state_q <= ST_REL;
							default: ;
						endcase
					end
				end
				ST_TICK1: state_q <= ST_TICK2;
				ST_TICK2: begin
					if (pos_sat >= len_rd) begin
						pos_q   <= pos_sat - len_rd;
						state_q <= ST_REL;
					end else begin
						pos_q   <= pos_sat;
						state_q <= ST_IDLE;
					end
				end
				// Release one sounding note per event.
				ST_REL: if (!ev_busy) begin
					if (idx_q < scnt_q) begin
						ev_q   <= '{kind: csns_pkg::EV_OFF, note: snd_q[idx_q[csns_pkg::SND_W-1:0]],
							slot: slot_q, last: 1'b0};
						pend_q <= 1'b1;
						idx_q  <= idx_q + 1'b1;
					end else begin
						scnt_q  <= '0;
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					k_q <= '0;
					if (act_q == csns_pkg::ACT_TICK) begin
						slot_q  <= (7'(slot_q) + 7'd1 >= eff_cnt) ? '0 : slot_q + 1'b1;
						state_q <= ST_SLOTRD;
					end else begin
						slot_q <= '0;
						pos_q  <= '0;
						if (act_q == csns_pkg::ACT_STOP) begin
							playing_q <= 1'b0;
							state_q   <= ST_STOPEV;
						end else begin
							playing_q <= 1'b1;
							state_q   <= ST_SLOTRD;
						end
					end
				end
				// Let the note count of the new slot come out of its RAM.
				ST_SLOTRD: state_q <= ST_SRD;
				ST_SRD: begin
					if (k_q < cur_ncnt && scnt_q < csns_pkg::SCNT_W'(csns_pkg::MAX_SOUNDING))
						state_q <= ST_SWAIT;
					else
						state_q <= ST_DONE;
				end
				ST_SWAIT: begin
					idx_q   <= '0;
					dup_q   <= 1'b0;
					state_q <= ST_SCMP;
				end
				// One duplicate compare a cycle.
				ST_SCMP: begin
					note_q <= note_rd;
					if (idx_q < scnt_q) begin
						if (snd_q[idx_q[csns_pkg::SND_W-1:0]] == note_rd) dup_q <= 1'b1;
						idx_q <= idx_q + 1'b1;
					end else begin
						state_q <= ST_SEMIT;
					end
				end
				ST_SEMIT: if (!ev_busy) begin
					if (!dup_q) begin
						snd_q[scnt_q[csns_pkg::SND_W-1:0]] <= note_q;
						scnt_q <= scnt_q + 1'b1;
						ev_q   <= '{kind: csns_pkg::EV_ON, note: note_q, slot: slot_q, last: 1'b0};
						pend_q <= 1'b1;
					end
					k_q     <= k_q + 1'b1;
					state_q <= ST_SRD;
				end
				ST_STOPEV: if (!ev_busy) begin
					ev_q    <= '{kind: csns_pkg::EV_ALL, note: 7'd0, slot: '0, last: 1'b0};
					pend_q  <= 1'b1;
					state_q <= ST_DONE;
				end
				// Send the held event, if any, as the last one, then wait until it is taken.
				ST_DONE: if (!ev_busy) begin
					if (pend_q) pend_q <= 1'b0;
					else state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tdata = {1'b0, out_q.slot, out_q.note, out_q.kind};
	assign m_tlast = out_q.last;

endmodule

// ===== hw/rtl/csns_checker.sv =====
// ----------------------------------------------------------------------------
// csns_checker
// Port-level checks of the chord slot note sequencer.
// ----------------------------------------------------------------------------
module csns_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic        m_tlast
);

	// A stalled transaction holds its payload.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata))
		else $error("output payload changed while stalled");

	// No event kind beyond all notes off.
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[1:0] != 2'd3)
		else $error("bad event kind");

	// All notes off carries note and slot zero and is marked last.
	a_all: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] == csns_pkg::EV_ALL |-> m_tdata[14:2] == 13'd0 && m_tlast)
		else $error("bad all notes off");

	// No new item is taken while the last event of an item waits.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready || !m_tlast)
		else $error("input taken during event");

endmodule

bind chord_slot_note_sequencer csns_checker u_csns_checker (
	.clk(clk), .arst_n(arst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
	.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
